// ----- sv/pno2d_pkg.sv -----
// ----------------------------------------------------------------------------
// pno2d_pkg
// Shared types, constants and the gradient selector for the 2D fractal noise
// block.
// ----------------------------------------------------------------------------
package pno2d_pkg;

  // Q16 fraction width and fade polynomial coefficients (6t^5 - 15t^4 + 10t^3)
  localparam int FRAC_W  = 16;
  localparam int FADE_C5 = 6;
  localparam int FADE_C4 = 15;
  localparam int FADE_C3 = 10;

  // Weight of the first octave: 1.0 in Q16
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Configuration register indexes
  localparam logic [1:0] REG_WRAP_PERIOD  = 2'd0;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE  = 2'd2;

  // Request kinds on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Gradient codes: low three bits of a corner hash
  localparam logic [2:0] GRAD_PX_PY = 3'd0;
  localparam logic [2:0] GRAD_NX_PY = 3'd1;
  localparam logic [2:0] GRAD_PX_NY = 3'd2;
  localparam logic [2:0] GRAD_NX_NY = 3'd3;
  localparam logic [2:0] GRAD_PX    = 3'd4;
  localparam logic [2:0] GRAD_NX    = 3'd5;
  localparam logic [2:0] GRAD_PY    = 3'd6;
  localparam logic [2:0] GRAD_NY    = 3'd7;

  typedef logic signed [17:0] offs_t;   // corner offset, Q16, [-1.0, 1.0)
  typedef logic signed [19:0] grad_t;   // gradient dot product and lerp values

  function automatic grad_t grad_dot(input logic [2:0] h, input offs_t dx, input offs_t dy);
    grad_t gx;
    grad_t gy;
    grad_t r;
    gx = grad_t'(dx);
    gy = grad_t'(dy);
    unique case (h)
      GRAD_PX_PY: r = gx + gy;
      GRAD_NX_PY: r = gy - gx;
      GRAD_PX_NY: r = gx - gy;
      GRAD_NX_NY: r = -gx - gy;
      GRAD_PX:    r = gx;
      GRAD_NX:    r = -gx;
      GRAD_PY:    r = gy;
      GRAD_NY:    r = -gy;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/perlin_noise_octaves_2d.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_octaves_2d
// Fractal 2D improved gradient noise, summed over octaves, normalized output.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) writes one permutation byte; it gives no result.
// An evaluate request (tuser = 1) first reduces the integer coordinates
// modulo the period bit by bit, then each octave runs 17 steps of a
// sequencer around one shared 21x21 multiplier and the single-port table,
// and a bit-serial divider normalizes the sum one quotient bit per cycle.
// The block takes one request at a time; a finished result waits in the
// output register while the next one runs.
// The whole permutation table must be loaded before the first evaluation.
module perlin_noise_octaves_2d
  import pno2d_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // table_index[7:0], table_value[15:8], x_coord[47:16], y_coord[79:48]
  input  logic [79:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // height[15:0]
  output logic [15:0] m_tdata,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TW   = $clog2(TABLE_DEPTH);
  localparam int PW   = $clog2(TABLE_DEPTH + 1);
  localparam int OW   = $clog2(MAX_OCTAVES + 1);
  localparam int WSW  = 17 + $clog2(MAX_OCTAVES);
  localparam int DW   = WSW + 2;
  localparam int ACW  = 35 + $clog2(MAX_OCTAVES);
  localparam int NW   = ACW;
  localparam int DCW  = $clog2(NW);
  localparam logic [4:0] LAST_STEP = 5'd16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_OCT  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic [8:0]  wrap_period;
  logic [3:0]  octave_count;
  logic [15:0] persistence;

  // sequencer
  logic [2:0]     state;
  logic [4:0]     step;
  logic [3:0]     ictr;
  logic [OW-1:0]  oct;
  logic [OW-1:0]  cnt;
  logic [PW-1:0]  period;
  logic [DCW-1:0] dctr;

  // per-request datapath
  logic [15:0]        xint, yint, fx, fy;
  logic [TW-1:0]      xi, yi;
  logic [7:0]         ha, hb;
  logic [2:0]         haa, hab, hba, hbb;
  logic [17:0]        u, v;
  logic [19:0]        px, py;
  logic signed [41:0] prod;
  grad_t              d0, d1, l0, l1, r0, r1, h;
  logic [16:0]        weight;
  logic [WSW-1:0]     wsum;
  logic signed [ACW-1:0] acc;
  logic               neg;
  logic [NW-1:0]      num;
  logic [DW-1:0]      rem, den;

  // table memory
  logic [7:0]    mem [TABLE_DEPTH];
  logic [TW-1:0] raddr;
  logic [7:0]    rdata;

  // combinational helpers
  logic               accept;
  logic [PW-1:0]      per_eff;
  logic [OW-1:0]      cnt_eff;
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] prod_r;
  logic signed [25:0] pr;
  logic [37:0]        poly;
  logic [19:0]        p_calc;
  logic [15:0]        fsel;
  logic [TW-1:0]      xn, yn;
  offs_t              dx0, dx1, dy0, dy1;
  logic [DW:0]        trial;
  logic [15:0]        sat;

  function automatic logic [TW-1:0] mstep(input logic [TW-1:0] m, input logic b,
                                          input logic [PW-1:0] p);
    logic [TW+1:0] t;
    t = {1'b0, m, b};
    if (t >= (TW+2)'(p)) t = t - (TW+2)'(p);
    return t[TW-1:0];
  endfunction

  // (a + y) mod depth, with a an 8-bit table value and y below the depth
  function automatic logic [TW-1:0] hidx(input logic [7:0] a, input logic [TW-1:0] y);
    logic [TW-1:0] m;
    logic [TW:0]   s;
    m = '0;
    for (int k = 7; k >= 0; k--) m = mstep(m, a[k], PW'(TABLE_DEPTH));
    s = {1'b0, m} + {1'b0, y};
    if (s >= (TW+1)'(TABLE_DEPTH)) s = s - (TW+1)'(TABLE_DEPTH);
    return s[TW-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (wrap_period == 9'd0) per_eff = PW'(1);
    else if (32'(wrap_period) > TABLE_DEPTH) per_eff = PW'(TABLE_DEPTH);
    else per_eff = PW'(wrap_period);
    if (octave_count == 4'd0) cnt_eff = OW'(1);
    else if (32'(octave_count) > MAX_OCTAVES) cnt_eff = OW'(MAX_OCTAVES);
    else cnt_eff = OW'(octave_count);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_period  <= 9'd4;
      octave_count <= 4'd5;
      persistence  <= 16'd13107;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WRAP_PERIOD:  wrap_period  <= cfg_data[8:0];
        REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        REG_PERSISTENCE:  persistence  <= cfg_data;
        default: ;
      endcase
    end
  end

  // permutation table
  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_LOAD && 32'(s_tdata[7:0]) < TABLE_DEPTH)
      mem[TW'(s_tdata[7:0])] <= s_tdata[15:8];
    rdata <= mem[raddr];
  end

  always_comb begin
    xn = (32'(xi) + 1 == 32'(period)) ? '0 : TW'(xi + 1'b1);
    yn = (32'(yi) + 1 == 32'(period)) ? '0 : TW'(yi + 1'b1);
    unique case (step)
      5'd0:    raddr = xi;
      5'd1:    raddr = xn;
      5'd2:    raddr = hidx(ha, yi);
      5'd3:    raddr = hidx(ha, yn);
      5'd4:    raddr = hidx(hb, yi);
      5'd5:    raddr = hidx(hb, yn);
      default: raddr = xi;
    endcase
  end

  // shared multiplier operands and rounding
  assign prod_r = prod + 42'sd32768;
  assign pr     = prod_r[41:16];
  assign fsel   = (step < 5'd3) ? fx : fy;
  assign poly   = 38'(prod[31:0]) * 38'(FADE_C5) + (38'(FADE_C3) << 32)
                - ((38'(fsel) * 38'(FADE_C4)) << 16);
  assign p_calc = 20'((poly + 38'd32768) >> 16);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      5'd0:  begin mul_a = {5'd0, fx};         mul_b = {5'd0, fx}; end
      5'd1:  begin mul_a = {4'd0, pr[16:0]};   mul_b = {5'd0, fx}; end
      5'd2:  begin mul_a = {4'd0, pr[16:0]};   mul_b = {1'b0, px}; end
      5'd3:  begin mul_a = {5'd0, fy};         mul_b = {5'd0, fy}; end
      5'd4:  begin mul_a = {4'd0, pr[16:0]};   mul_b = {5'd0, fy}; end
      5'd5:  begin mul_a = {4'd0, pr[16:0]};   mul_b = {1'b0, py}; end
      5'd8:  begin mul_a = {d0[19], d0};       mul_b = {3'd0, u};  end
      5'd9:  begin mul_a = {d1[19], d1};       mul_b = {3'd0, u};  end
      5'd12: begin mul_a = {d0[19], d0};       mul_b = {3'd0, v};  end
      5'd14: begin mul_a = {h[19], h};         mul_b = {4'd0, weight}; end
      5'd15: begin mul_a = {4'd0, weight};     mul_b = {5'd0, persistence}; end
      default: ;
    endcase
  end

  assign dx0 = offs_t'({2'b00, fx});
  assign dx1 = offs_t'({2'b11, fx});
  assign dy0 = offs_t'({2'b00, fy});
  assign dy1 = offs_t'({2'b11, fy});

  assign trial = {rem, num[NW-1]} - {1'b0, den};

  always_comb begin
    if (neg) sat = (num > NW'(32768)) ? 16'h8000 : 16'(-num);
    else     sat = (num > NW'(32767)) ? 16'h7fff : num[15:0];
  end

  // datapath and sequencer
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      ictr  <= '0;
      oct   <= '0;
      dctr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == CMD_EVAL) begin
            period <= per_eff;
            cnt    <= cnt_eff;
            xint   <= s_tdata[47:32];
            fx     <= s_tdata[31:16];
            yint   <= s_tdata[79:64];
            fy     <= s_tdata[63:48];
            xi     <= '0;
            yi     <= '0;
            weight <= WEIGHT_ONE;
            wsum   <= '0;
            acc    <= '0;
            ictr   <= '0;
            oct    <= '0;
            step   <= '0;
            state  <= S_INIT;
          end
        end
        S_INIT: begin
          // integer part reduced mod period, one bit per cycle
          xi   <= mstep(xi, xint[15], period);
          yi   <= mstep(yi, yint[15], period);
          xint <= xint << 1;
          yint <= yint << 1;
          ictr <= ictr + 1'b1;
          if (ictr == 4'd15) state <= S_OCT;
        end
        S_OCT: begin
          step <= step + 1'b1;
          unique case (step)
            5'd1:  begin ha <= rdata; px <= p_calc; end
            5'd2:  hb <= rdata;
            5'd3:  begin haa <= rdata[2:0]; u <= pr[17:0]; end
            5'd4:  begin hab <= rdata[2:0]; py <= p_calc; end
            5'd5:  hba <= rdata[2:0];
            5'd6:  begin hbb <= rdata[2:0]; v <= pr[17:0]; end
            5'd7: begin
              d0 <= grad_dot(hba, dx1, dy0) - grad_dot(haa, dx0, dy0);
              l0 <= grad_dot(haa, dx0, dy0);
              d1 <= grad_dot(hbb, dx1, dy1) - grad_dot(hab, dx0, dy1);
              l1 <= grad_dot(hab, dx0, dy1);
            end
            5'd9:  r0 <= l0 + pr[19:0];
            5'd10: r1 <= l1 + pr[19:0];
            5'd11: d0 <= r1 - r0;
            5'd13: h  <= r0 + pr[19:0];
            5'd15: acc <= acc + ACW'(prod);
            LAST_STEP: begin
              wsum   <= wsum + WSW'(weight);
              weight <= pr[16:0];
              step   <= '0;
              if (oct + 1'b1 == cnt) begin
                state <= S_PREP;
              end else begin
                // next octave: doubled coordinate shifts one fraction bit up
                oct <= oct + 1'b1;
                xi  <= mstep(xi, fx[15], period);
                yi  <= mstep(yi, fy[15], period);
                fx  <= fx << 1;
                fy  <= fy << 1;
              end
            end
            default: ;
          endcase
        end
        S_PREP: begin
          neg   <= acc[ACW-1];
          num   <= (acc[ACW-1] ? NW'(-acc) : NW'(acc)) + NW'({wsum, 1'b0});
          den   <= {wsum, 2'b00};
          rem   <= '0;
          dctr  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[DW]) begin
            rem <= trial[DW-1:0];
            num <= {num[NW-2:0], 1'b1};
          end else begin
            rem <= {rem[DW-2:0], num[NW-1]};
            num <= {num[NW-2:0], 1'b0};
          end
          dctr <= dctr + 1'b1;
          if (dctr == DCW'(NW - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= sat;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractal 2D noise block. Loads the permutation
// table, runs directed and random evaluate/load streams under several
// register settings with random idling on both stream sides, and compares
// every height against a behavioral predictor kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
  import pno2d_pkg::*;

  localparam int DEPTH       = 256;
  localparam int OCT_MAX     = 8;
  localparam int DRAIN_WAIT  = 300;    // covers one full 8-octave evaluate
  localparam int IDLE_PCT    = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  perlin_noise_octaves_2d uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  perm_copy [DEPTH];
  logic [8:0]  period_reg  = 9'd4;
  logic [3:0]  octaves_reg = 4'd5;
  logic [15:0] persist_reg = 16'd13107;

  logic [15:0] heights_pending [$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          hold_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned fade_q16(longint unsigned t);
    longint unsigned t2, t3, poly, p;
    t2   = (t * t + 32768) >> 16;
    t3   = (t2 * t + 32768) >> 16;
    poly = (6 * t * t + (longint'(10) << 32)) - ((15 * t) << 16);
    p    = (poly + 32768) >> 16;
    return (t3 * p + 32768) >> 16;
  endfunction

  function automatic longint corner_grad(logic [2:0] h, longint dx, longint dy);
    case (h)
      GRAD_PX_PY: return dx + dy;
      GRAD_NX_PY: return dy - dx;
      GRAD_PX_NY: return dx - dy;
      GRAD_NX_NY: return -dx - dy;
      GRAD_PX:    return dx;
      GRAD_NX:    return -dx;
      GRAD_PY:    return dy;
      default:    return -dy;
    endcase
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return a + (((b - a) * w + 32768) >>> 16);
  endfunction

  function automatic longint perm_at(longint unsigned i);
    return longint'(perm_copy[i % DEPTH]);
  endfunction

  function automatic longint octave_height(longint unsigned sx, longint unsigned sy,
                                           longint unsigned period);
    longint unsigned xi, yi, xn, yn;
    longint fx, fy, u, v, r0, r1;
    logic [2:0] aa, ab, ba, bb;
    xi = (sx >> 16) % period;
    yi = (sy >> 16) % period;
    xn = (xi + 1) % period;
    yn = (yi + 1) % period;
    fx = longint'(sx & 64'hFFFF);
    fy = longint'(sy & 64'hFFFF);
    u  = longint'(fade_q16(fx));
    v  = longint'(fade_q16(fy));
    aa = 3'(perm_at(perm_at(xi) + yi));
    ab = 3'(perm_at(perm_at(xi) + yn));
    ba = 3'(perm_at(perm_at(xn) + yi));
    bb = 3'(perm_at(perm_at(xn) + yn));
    r0 = lerp_q16(corner_grad(aa, fx, fy), corner_grad(ba, fx - 65536, fy), u);
    r1 = lerp_q16(corner_grad(ab, fx, fy - 65536),
                  corner_grad(bb, fx - 65536, fy - 65536), u);
    return lerp_q16(r0, r1, v);
  endfunction

  function automatic logic [15:0] predict_height(logic [31:0] x, logic [31:0] y);
    longint unsigned period, count, weight, wsum, den, mag;
    longint acc, q;
    period = (period_reg == 0) ? 1 : (period_reg > DEPTH) ? DEPTH : period_reg;
    count  = (octaves_reg == 0) ? 1 : (octaves_reg > OCT_MAX) ? OCT_MAX : octaves_reg;
    weight = 65536;
    wsum   = 0;
    acc    = 0;
    for (int i = 0; i < count; i++) begin
      acc += octave_height(longint'(x) << i, longint'(y) << i, period) * longint'(weight);
      wsum += weight;
      weight = (weight * persist_reg + 32768) >> 16;
    end
    den = wsum * 4;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    mag = (mag + den / 2) / den;
    if (acc < 0) q = (mag > 32768) ? -32768 : -longint'(mag);
    else q = (mag > 32767) ? 32767 : longint'(mag);
    return q[15:0];
  endfunction

  // ---------------- drivers ----------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // returns at the rising edge of acceptance with s_tvalid still high
  task automatic send_request(logic cmd, logic [7:0] idx, logic [7:0] val,
                              logic [31:0] x, logic [31:0] y);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {y, x, val, idx};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_LOAD) perm_copy[idx] = val;
    else heights_pending = {heights_pending, predict_height(x, y)};
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_request(CMD_LOAD, idx, val, $urandom, $urandom);
  endtask

  task automatic send_eval(logic [31:0] x, logic [31:0] y);
    send_request(CMD_EVAL, 8'($urandom), 8'($urandom), x, y);
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (heights_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic [8:0] period, logic [3:0] octaves, logic [15:0] persist);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_WRAP_PERIOD; cfg_data <= 16'(period);
    @(negedge clk);
    cfg_index <= REG_OCTAVE_COUNT; cfg_data <= 16'(octaves);
    @(negedge clk);
    cfg_index <= REG_PERSISTENCE; cfg_data <= persist;
    @(negedge clk);
    cfg_write <= 1'b0;
    period_reg = period; octaves_reg = octaves; persist_reg = persist;
  endtask

  // ---------------- checker ----------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (heights_pending.size() == 0) begin
        $error("unexpected height result %0d", $signed(m_tdata));
        errors++;
      end else begin
        if (m_tdata !== heights_pending[0]) begin
          $error("height mismatch: expected %0d actual %0d",
                 $signed(heights_pending[0]), $signed(m_tdata));
          errors++;
        end
        void'(heights_pending.pop_front());
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_table_load;
    for (int i = 0; i < DEPTH; i++)
      send_load(i[7:0], (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hFF : 8'($urandom));
  endtask

  task automatic test_directed_eval;
    // reset settings first, then the extremes and the clamped register cases
    send_eval(32'h0, 32'h0);
    send_eval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_eval(32'h0000_8000, 32'h0003_8000);
    send_eval(32'h0003_FFFF, 32'h0004_0001);
    set_config(9'd1, 4'd1, 16'd0);
    send_eval(32'h1234_5678, 32'h8765_4321);
    send_eval(32'hFFFF_FFFF, 32'h0);
    set_config(9'd256, 4'd8, 16'hFFFF);
    send_eval(32'h00FF_FFFF, 32'h0100_0000);
    send_eval(32'hFFFF_0000, 32'h0000_FFFF);
    set_config(9'd0, 4'd0, 16'h8000);          // zero period, zero octaves
    send_eval(32'h5555_AAAA, 32'hAAAA_5555);
    set_config(9'd511, 4'd15, 16'h0001);       // both beyond their limits
    send_eval(32'hDEAD_BEEF, 32'hCAFE_F00D);
    set_config(9'd257, 4'd9, 16'd13107);
    send_eval(32'h7FFF_FFFF, 32'h8000_0000);
    send_load(8'hFF, 8'h00);                   // unused coords on a load
    send_eval(32'h00FF_8000, 32'h00FF_8000);
  endtask

  task automatic test_backpressure;
    set_config(9'd16, 4'd3, 16'h8000);
    hold_cycles = 800;
    for (int i = 0; i < 8; i++) send_eval($urandom, $urandom);
  endtask

  task automatic test_random_mix;
    logic [31:0] x, y;
    for (int ph = 0; ph < 10; ph++) begin
      set_config(9'($urandom_range(0, 300)), 4'($urandom_range(0, 9)), 16'($urandom));
      calm = (ph == 4);
      for (int n = 0; n < 87; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_load(8'($urandom), 8'($urandom));
        end else begin
          x = $urandom;
          y = $urandom;
          if ($urandom_range(0, 3) == 0) begin
            x = x & 32'h000F_FFFF;
            y = y & 32'h000F_FFFF;
          end
          send_eval(x, y);
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) perm_copy[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_table_load();
    test_directed_eval();
    test_backpressure();
    test_random_mix();
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
